[hw/rtl/pbp_pkg.sv]
// ----------------------------------------------------------------------------
// pbp_pkg: shared types and constants of the encryption block parser
// Phase codes, padding constants and the result beat layout.
// ----------------------------------------------------------------------------
package pbp_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CntW    = 10;
  localparam int unsigned TypeW   = 2;
  localparam int unsigned PlenW   = 9;
  localparam int unsigned ModW    = 10;

  localparam logic [ByteW-1:0] PadByte  = 8'hFF;
  localparam logic [ByteW-1:0] MaxType  = 8'd2;
  localparam logic [CntW-1:0]  MinPad   = 10'd8;
  localparam logic [CntW-1:0]  CntMax   = 10'd1023;
  localparam logic [ModW-1:0]  ModReset = 10'd128;

  // parser phase
  typedef enum logic [1:0] {
    PH_TYPE = 2'd0,
    PH_PAD  = 2'd1,
    PH_DATA = 2'd2,
    PH_ERR  = 2'd3
  } pbp_phase_e;

  // one result beat
  typedef struct packed {
    logic [ByteW-1:0] payload_byte;
    logic             payload_valid;
    logic             block_end;
    logic             format_error;
    logic [TypeW-1:0] block_type;
    logic [PlenW-1:0] payload_length;
  } pbp_result_t;

endpackage

[hw/rtl/pkcs1_block_parser.sv]
// ----------------------------------------------------------------------------
// pkcs1_block_parser: streaming encryption block format check
// Byte register, per-byte check logic and result register.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | beat
//  in      | input     | in_valid_i/in_stall_o   | eb_byte_i, last_byte_i
//  out     | output    | out_valid_o/out_stall_i | payload, end, error, type, length
//  cfg     | input     | cfg_we_i                | cfg_wdata_i (modulus_bytes)
//
// one byte per cycle unless the output stalls; a result is offered from the
// result register after its byte has passed the byte register and pbp_parse
// reset clears the block state and sets modulus_bytes to 128
// a stalled output holds its beat; one more byte is held in the input register
// ----------------------------------------------------------------------------
module pkcs1_block_parser import pbp_pkg::*; #(
  parameter int unsigned MAX_MOD_BYTES = 512
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [ModW-1:0]  cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [ByteW-1:0] eb_byte_i,
  input  logic             last_byte_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [ByteW-1:0] payload_byte_o,
  output logic             payload_valid_o,
  output logic             block_end_o,
  output logic             format_error_o,
  output logic [TypeW-1:0] block_type_o,
  output logic [PlenW-1:0] payload_length_o
);

  logic [ModW-1:0]  modulus_q;
  logic             s1_valid_q, s2_valid_q;
  logic [ByteW-1:0] s1_byte_q;
  logic             s1_last_q;
  pbp_result_t      s2_result_q, result;
  logic             s2_ready, s1_ready, s1_move;

  // pipeline flow
  assign s2_ready   = !s2_valid_q || !out_stall_i;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign s1_move    = s1_valid_q && s2_ready;
  assign in_stall_o = !s1_ready;

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= ModReset;
    end else if (cfg_we_i) begin
      modulus_q <= cfg_wdata_i;
    end
  end

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_ready) begin
      s1_byte_q <= eb_byte_i;
      s1_last_q <= last_byte_i;
    end
    if (s1_move) begin
      s2_result_q <= result;
    end
  end

  pbp_parse #(
    .MaxModBytes (MAX_MOD_BYTES)
  ) u_parse (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (s1_move),
    .byte_i          (s1_byte_q),
    .last_i          (s1_last_q),
    .modulus_bytes_i (modulus_q),
    .result_o        (result)
  );

  assign out_valid_o      = s2_valid_q;
  assign payload_byte_o   = s2_result_q.payload_byte;
  assign payload_valid_o  = s2_result_q.payload_valid;
  assign block_end_o      = s2_result_q.block_end;
  assign format_error_o   = s2_result_q.format_error;
  assign block_type_o     = s2_result_q.block_type;
  assign payload_length_o = s2_result_q.payload_length;

`ifndef SYNTHESIS
  a_stall_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && s2_valid_q && out_stall_i))
    else $error("input stalled with room in the pipeline");
  a_mid_block_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !block_end_o) |->
      (!format_error_o && block_type_o == '0 && payload_length_o == '0))
    else $error("end of block fields set mid block");
  a_error_no_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && format_error_o) |-> (payload_length_o == '0))
    else $error("payload length reported on a bad block");
  a_payload_zeroed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !payload_valid_o) |-> (payload_byte_o == '0))
    else $error("payload byte not cleared");
`endif

endmodule

[hw/rtl/pbp_parse.sv]
// ----------------------------------------------------------------------------
// pbp_parse: per-byte padding check
// Holds the block state and computes one result beat per stepped byte.
// ----------------------------------------------------------------------------
module pbp_parse import pbp_pkg::*; #(
  parameter int unsigned MaxModBytes = 512
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [ByteW-1:0]  byte_i,
  input  logic              last_i,
  input  logic [ModW-1:0]   modulus_bytes_i,
  output pbp_result_t       result_o
);

  localparam logic [ModW:0] ModLimit = (ModW+1)'(MaxModBytes);

  pbp_phase_e       phase_q, phase_d;
  logic [CntW-1:0]  byte_count_q, byte_count_d;
  logic [CntW-1:0]  pad_count_q, pad_count_d;
  logic [TypeW-1:0] type_q, type_d;

  logic [CntW:0]    total;
  logic [CntW:0]    used;
  logic [CntW:0]    plen;
  logic             err;

  // next phase and padding count for this byte
  always_comb begin
    phase_d     = phase_q;
    pad_count_d = pad_count_q;
    type_d      = type_q;
    case (phase_q)
      PH_TYPE: begin
        if (byte_i > MaxType) begin
          phase_d = PH_ERR;
        end else begin
          type_d  = byte_i[TypeW-1:0];
          phase_d = PH_PAD;
        end
      end
      PH_PAD: begin
        if (byte_i == '0) begin
          phase_d = (pad_count_q >= MinPad) ? PH_DATA : PH_ERR;
        end else if (type_q <= TypeW'(1) && byte_i != PadByte) begin
          phase_d = PH_ERR;
        end else if (pad_count_q < CntMax) begin
          pad_count_d = pad_count_q + CntW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // end of block checks
  always_comb begin
    total = {1'b0, byte_count_q} + (CntW+1)'(1);
    used  = {1'b0, pad_count_d} + (CntW+1)'(2);
    plen  = (total >= used) ? (total - used) : '0;
    err   = (modulus_bytes_i == '0) || ({1'b0, modulus_bytes_i} > ModLimit) ||
            (total != ({1'b0, modulus_bytes_i} - (ModW+1)'(1))) ||
            (phase_d != PH_DATA);
  end

  // result beat
  always_comb begin
    result_o                = '0;
    result_o.payload_valid  = (phase_q == PH_DATA);
    result_o.payload_byte   = result_o.payload_valid ? byte_i : '0;
    if (last_i) begin
      result_o.block_end    = 1'b1;
      result_o.format_error = err;
      result_o.block_type   = type_d;
      if (!err) begin
        result_o.payload_length = (plen > (CntW+1)'({PlenW{1'b1}})) ?
                                  {PlenW{1'b1}} : plen[PlenW-1:0];
      end
    end
  end

  // next byte count
  always_comb begin
    byte_count_d = byte_count_q;
    if (byte_count_q < CntMax) begin
      byte_count_d = byte_count_q + CntW'(1);
    end
  end

  // block state, cleared after the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_TYPE;
      byte_count_q <= '0;
      pad_count_q  <= '0;
      type_q       <= '0;
    end else if (step_i) begin
      if (last_i) begin
        phase_q      <= PH_TYPE;
        byte_count_q <= '0;
        pad_count_q  <= '0;
        type_q       <= '0;
      end else begin
        phase_q      <= phase_d;
        byte_count_q <= byte_count_d;
        pad_count_q  <= pad_count_d;
        type_q       <= type_d;
      end
    end
  end

`ifndef SYNTHESIS
  a_pad_only_in_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_TYPE) |-> (pad_count_q == '0 && type_q == '0))
    else $error("padding count or type set before the type byte");
  a_data_needs_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA) |-> (pad_count_q >= MinPad))
    else $error("payload phase with short padding");
  a_type_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    type_q != 2'd3)
    else $error("stored block type out of range");
`endif

endmodule

[bench/tb_pkcs1_block_parser.sv]
// ----------------------------------------------------------------------------
// tb_pkcs1_block_parser: self-checking bench of the encryption block parser
// Feeds whole blocks byte by byte with random gaps and output stalls, and
// predicts each result beat in the bench. One block at the reset modulus,
// then a short hand-written table, then random blocks, mostly well-formed,
// under several moduli. Every result beat is checked field by field.
// ----------------------------------------------------------------------------
module tb_pkcs1_block_parser;
  import pbp_pkg::*;

  localparam int unsigned MaxModBytes = 512;
  localparam int unsigned QuietLimit  = 1000;
  localparam int unsigned RandItems   = 1300;

  // ways a generated block is shaped
  typedef enum {
    BK_GOOD, BK_SEP_LAST, BK_BAD_LEN, BK_BAD_TYPE, BK_BAD_PAD,
    BK_EARLY_SEP, BK_NO_SEP, BK_NOISE, BK_LONG
  } blk_kind_e;

  // one row of the hand-written table
  typedef struct {
    logic [7:0] b;
    logic       lst;
    logic       typed;
    logic [7:0] pb;
    logic       pv;
    logic       be;
    logic       fe;
    logic [1:0] bt;
    logic [8:0] pl;
  } dir_row_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [ModW-1:0]  cfg_wdata = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [ByteW-1:0] eb_byte = '0;
  logic             last_byte = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [ByteW-1:0] payload_byte;
  logic             payload_valid;
  logic             block_end;
  logic             format_error;
  logic [TypeW-1:0] block_type;
  logic [PlenW-1:0] payload_length;

  // typed expectation that rides along with the current input beat
  logic        beat_typed = 1'b0;
  pbp_result_t beat_want = '0;

  // bench-side copy of the parser state and register
  pbp_phase_e      ph_q;
  logic [CntW-1:0] bytes_seen;
  logic [CntW-1:0] pads_seen;
  logic [1:0]      type_got;
  logic [ModW-1:0] mod_bytes;

  pbp_result_t pending_results [$];
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  bit          tx_gappy = 1'b0;
  bit          rx_gappy = 1'b0;
  bit          squeeze_req = 1'b0;

  // modulus 12 gives 11-byte blocks
  dir_row_t dir_tab [24] = '{
    '{8'hFF, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, 1'b1, 2'd0, 9'd0},
    '{8'h03, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, 1'b1, 2'd0, 9'd0},
    '{8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 2'd0, 9'd0},
    '{8'hFF, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 2'd0, 9'd0},
    '{8'hFF, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 2'd0, 9'd0},
    '{8'hFF, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 2'd0, 9'd0},
    '{8'hFF, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 2'd0, 9'd0},
    '{8'hFF, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 2'd0, 9'd0},
    '{8'hFF, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 2'd0, 9'd0},
    '{8'hFF, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 2'd0, 9'd0},
    '{8'hFF, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 2'd0, 9'd0},
    '{8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 2'd0, 9'd0},
    '{8'h80, 1'b1, 1'b1, 8'h80, 1'b1, 1'b1, 1'b0, 2'd0, 9'd1},
    '{8'h02, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 2'd0, 9'd0},
    '{8'h01, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 2'd0, 9'd0},
    '{8'h02, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 2'd0, 9'd0},
    '{8'h04, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 2'd0, 9'd0},
    '{8'h08, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 2'd0, 9'd0},
    '{8'h10, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 2'd0, 9'd0},
    '{8'h20, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 2'd0, 9'd0},
    '{8'h40, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 2'd0, 9'd0},
    '{8'h80, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 2'd0, 9'd0},
    '{8'h7F, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 2'd0, 9'd0},
    '{8'h00, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, 1'b0, 2'd2, 9'd0}
  };

  pkcs1_block_parser #(
    .MAX_MOD_BYTES(MaxModBytes)
  ) DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .eb_byte_i       (eb_byte),
    .last_byte_i     (last_byte),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .payload_byte_o  (payload_byte),
    .payload_valid_o (payload_valid),
    .block_end_o     (block_end),
    .format_error_o  (format_error),
    .block_type_o    (block_type),
    .payload_length_o(payload_length)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // back to waiting for a type byte
  function automatic void restart_block();
    ph_q       = PH_TYPE;
    bytes_seen = '0;
    pads_seen  = '0;
    type_got   = '0;
  endfunction

  // advance the parser copy by one byte and return its result beat
  function automatic pbp_result_t parse_byte(input logic [7:0] b, input logic lst);
    pbp_result_t r;
    int          total;
    int          plen;
    logic        bad;
    r = '0;
    case (ph_q)
      PH_TYPE: begin
        if (b > MaxType) ph_q = PH_ERR;
        else begin
          type_got = b[1:0];
          ph_q = PH_PAD;
        end
      end
      PH_PAD: begin
        if (b == 8'h00) ph_q = (pads_seen >= MinPad) ? PH_DATA : PH_ERR;
        else if (type_got <= 2'd1 && b != PadByte) ph_q = PH_ERR;
        else if (pads_seen < CntMax) pads_seen++;
      end
      PH_DATA: begin
        r.payload_valid = 1'b1;
        r.payload_byte  = b;
      end
      default: ;
    endcase
    if (lst) begin
      total = int'(bytes_seen) + 1;
      bad = (mod_bytes < 1) || (int'(mod_bytes) > MaxModBytes) ||
            (total != int'(mod_bytes) - 1) || (ph_q != PH_DATA);
      r.block_end    = 1'b1;
      r.format_error = bad;
      r.block_type   = type_got;
      if (!bad) begin
        plen = total - 2 - int'(pads_seen);
        if (plen < 0) plen = 0;
        if (plen > 511) plen = 511;
        r.payload_length = 9'(plen);
      end
      restart_block();
    end else if (bytes_seen < CntMax) begin
      bytes_seen++;
    end
    return r;
  endfunction

  function automatic void cmp_field(input string name, input int unsigned want,
                                    input int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 200)
        $display("%0t: %s expected %0d got %0d", $time, name, want, got);
    end
  endfunction

  // beat monitor: results checked before new expectations are queued
  always @(posedge clk) begin
    pbp_result_t want;
    pbp_result_t got;
    pbp_result_t guess;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = {payload_byte, payload_valid, block_end, format_error, block_type,
               payload_length};
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 200)
            $display("%0t: result beat with nothing expected, expected none got %h",
                     $time, got);
        end else begin
          want = pending_results.pop_front();
          cmp_field("payload_byte", want.payload_byte, got.payload_byte);
          cmp_field("payload_valid", want.payload_valid, got.payload_valid);
          cmp_field("block_end", want.block_end, got.block_end);
          cmp_field("format_error", want.format_error, got.format_error);
          cmp_field("block_type", want.block_type, got.block_type);
          cmp_field("payload_length", want.payload_length, got.payload_length);
        end
      end
      if (in_valid && !in_stall) begin
        guess = parse_byte(eb_byte, last_byte);
        pending_results.push_back(beat_typed ? beat_want : guess);
      end
    end
  end

  // result side: random hold-off per beat, one long squeeze on request
  initial begin : result_sink
    int unsigned hold;
    int unsigned taken;
    taken = 0;
    @(posedge rst_n);
    forever begin
      if (taken % 40 == 0) rx_gappy = ($urandom_range(0, 2) != 0);
      hold = rx_gappy ? $urandom_range(0, 14) : 0;
      if (squeeze_req) begin
        hold = 120;
        squeeze_req = 1'b0;
      end
      @(negedge clk);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  // watchdog on cycles with no beat moving on either side
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    @(posedge rst_n);
    while (quiet < QuietLimit) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  // offer one input beat after a random gap and wait until it is taken
  task automatic put_byte(input logic [7:0] b, input logic lst, input logic typed,
                          input pbp_result_t want);
    int unsigned gap;
    gap = tx_gappy ? $urandom_range(0, 14) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    eb_byte    <= b;
    last_byte  <= lst;
    beat_typed <= typed;
    beat_want  <= want;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // stop offering and let every expected beat come out
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_modulus(input logic [ModW-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    mod_bytes = v;
  endtask

  function automatic blk_kind_e pick_kind();
    case ($urandom_range(0, 19))
      0, 1:    return BK_SEP_LAST;
      2:       return BK_BAD_LEN;
      3:       return BK_BAD_TYPE;
      4:       return BK_BAD_PAD;
      5:       return BK_EARLY_SEP;
      6:       return BK_NO_SEP;
      7:       return BK_NOISE;
      default: return BK_GOOD;
    endcase
  endfunction

  // build one block of the given shape and push it through
  task automatic send_block(input int len, input blk_kind_e kind);
    logic [7:0]  blk [$];
    logic [1:0]  t;
    int          npad;
    pbp_result_t none;
    none = '0;
    if (kind == BK_BAD_LEN) begin
      if ($urandom_range(0, 1) == 1 || len <= 4) len = len + $urandom_range(1, 3);
      else len = len - $urandom_range(1, 3);
    end
    t = (kind == BK_BAD_PAD) ? 2'($urandom_range(0, 1)) : 2'($urandom_range(0, 2));
    case (kind)
      BK_SEP_LAST:  npad = len - 2;
      BK_EARLY_SEP: npad = $urandom_range(0, 7);
      BK_NO_SEP:    npad = len - 1;
      BK_LONG:      npad = len - 4;
      default:      npad = (len >= 10) ? $urandom_range(8, len - 2) : len - 2;
    endcase
    if (kind == BK_NOISE) begin
      repeat (len) blk.push_back(8'($urandom));
    end else begin
      blk.push_back({6'd0, t});
      if (kind == BK_BAD_TYPE) blk[0] = 8'($urandom_range(3, 255));
      repeat (npad) blk.push_back((t == 2'd2) ? 8'($urandom_range(1, 255)) : PadByte);
      if (kind == BK_BAD_PAD) blk[$urandom_range(1, npad)] = 8'($urandom_range(1, 254));
      blk.push_back(8'h00);
      while (blk.size() < len) blk.push_back(8'($urandom));
    end
    while (blk.size() > len) void'(blk.pop_back());
    tx_gappy = ($urandom_range(0, 3) != 0);
    foreach (blk[i]) put_byte(blk[i], i == blk.size() - 1, 1'b0, none);
  endtask

  // stimulus
  initial begin : stimulus
    pbp_result_t     want;
    logic [ModW-1:0] mv;
    int unsigned     phase_no;
    mod_bytes = ModReset;
    restart_block();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // reset value of the modulus register: one well-formed 127-byte block
    send_block(int'(ModReset) - 1, BK_GOOD);
    drain();

    // hand-written table
    write_modulus(10'd12);
    tx_gappy = 1'b0;
    foreach (dir_tab[i]) begin
      want = {dir_tab[i].pb, dir_tab[i].pv, dir_tab[i].be, dir_tab[i].fe,
              dir_tab[i].bt, dir_tab[i].pl};
      put_byte(dir_tab[i].b, dir_tab[i].lst, dir_tab[i].typed, want);
    end
    drain();

    // block long enough to saturate both counters; wrapped counts would
    // make it look like a well-formed 11-byte block
    squeeze_req = 1'b1;
    send_block(1035, BK_LONG);
    drain();

    // out-of-range modulus settings fail every block
    write_modulus(10'd1023);
    repeat (2) send_block($urandom_range(8, 30), pick_kind());
    drain();
    write_modulus(10'd0);
    repeat (2) send_block($urandom_range(8, 30), pick_kind());
    drain();

    // random phases with small moduli
    phase_no = 0;
    do begin
      mv = ($urandom_range(0, 3) == 0) ? 10'd12 : 10'($urandom_range(12, 40));
      write_modulus(mv);
      if (phase_no == 0) squeeze_req = 1'b1;
      repeat (8) send_block(int'(mv) - 1, pick_kind());
      drain();
      phase_no++;
    end while (items_sent < RandItems);

    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/pbp_pkg.sv
hw/rtl/pbp_parse.sv
hw/rtl/pkcs1_block_parser.sv
bench/tb_pkcs1_block_parser.sv
